[src/charge_port_lock_sequencer_top_macros.svh]
// assertion macros used by the checker file of the charge port lock sequencer
// no dependencies; every macro expands to one labeled concurrent assertion
`ifndef CHARGE_PORT_LOCK_SEQUENCER_TOP_MACROS_SVH
`define CHARGE_PORT_LOCK_SEQUENCER_TOP_MACROS_SVH

// property that must hold at every clock edge outside reset
`define CPLS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error(msg);

// when ante holds, cons must hold at the next clock edge
`define CPLS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cpls_pkg.sv]
// types, codes and constants of the charge port lock sequencer
// no dependencies; used by the interfaces, the core, the top level and the checker
package cpls_pkg;

  localparam int MAX_PORTS = 8;
  localparam int PORTS_DEF = 6;

  localparam int KIND_W     = 2;
  localparam int PORT_W     = 3;
  localparam int STATE_W    = 3;
  localparam int MASK_W     = 6;
  localparam int TICK_W     = 8;
  localparam int PHASE_W    = 2;
  localparam int REG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int PORT_CMP_W = 4;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STATE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // port states
  localparam logic [STATE_W-1:0] ST_UNDEF        = 3'd0;
  localparam logic [STATE_W-1:0] ST_IDLE         = 3'd1;
  localparam logic [STATE_W-1:0] ST_DISCONNECTED = 3'd2;
  localparam logic [STATE_W-1:0] ST_CHARGE       = 3'd5;
  localparam logic [STATE_W-1:0] ST_FAN          = 3'd6;

  // sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE   = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DRIVE  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_SETTLE = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_DRIVE_TICKS  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_SETTLE_TICKS = 1'd1;

  localparam logic [TICK_W-1:0] DRIVE_TICKS_RST  = 8'd60;
  localparam logic [TICK_W-1:0] SETTLE_TICKS_RST = 8'd10;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [PORT_W-1:0]  port;
    logic [STATE_W-1:0] new_state;
  } item_t;

  typedef struct packed {
    logic [MASK_W-1:0]  motor_enable;
    logic               drive_lock;
    logic               drive_unlock;
    logic               allowed;
    logic [MASK_W-1:0]  locked_mask;
    logic [PHASE_W-1:0] phase_now;
  } result_t;

  typedef struct packed {
    logic                  en;
    logic [REG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

[src/cpls_if.sv]
// valid/ready channel interfaces for input words and result words
// depends on cpls_pkg for the field widths
interface cpls_item_if;
  logic                          valid;
  logic                          ready;
  logic [cpls_pkg::KIND_W-1:0]   kind;
  logic [cpls_pkg::PORT_W-1:0]   port;
  logic [cpls_pkg::STATE_W-1:0]  new_state;

  modport source (output valid, output kind, output port, output new_state, input ready);
  modport sink   (input valid, input kind, input port, input new_state, output ready);
endinterface

interface cpls_result_if;
  logic                          valid;
  logic                          ready;
  logic [cpls_pkg::MASK_W-1:0]   motor_enable;
  logic                          drive_lock;
  logic                          drive_unlock;
  logic                          allowed;
  logic [cpls_pkg::MASK_W-1:0]   locked_mask;
  logic [cpls_pkg::PHASE_W-1:0]  phase_now;

  modport source (output valid, output motor_enable, output drive_lock, output drive_unlock,
                  output allowed, output locked_mask, output phase_now, input ready);
  modport sink   (input valid, input motor_enable, input drive_lock, input drive_unlock,
                  input allowed, input locked_mask, input phase_now, output ready);
endinterface

[src/charge_port_lock_sequencer_top.sv]
// Charge port lock sequencer: drives one port lock motor at a time so that the
// confirmed lock mask follows the wanted lock mask set by port state words, and
// answers charge/fan permission queries from the confirmed mask. Every input word
// gives exactly one result word. Throughput is one word per clock while the result
// channel takes its words: a word is captured in the input register, its event and
// the start check are evaluated in one pass of the core logic against the state
// flops, and the result is registered in the output register once that register
// is free, from where the receiver takes it. The core state is written in the same
// cycle the word moves to the output register, which is what lets the next word
// follow directly behind. While a result word waits, the input register can still
// take one word; after that the input is held off until the output register drains.
// Configuration (drive_ticks, settle_ticks) is written through wr_en/wr_index/
// wr_data; there is no read-back. No clearing pass is needed after reset.
// depends on cpls_pkg, cpls_if and cpls_core
module charge_port_lock_sequencer_top #(
  parameter int PORTS = cpls_pkg::PORTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [cpls_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [cpls_pkg::CFG_DATA_W-1:0] wr_data,
  cpls_item_if.sink                       item,
  cpls_result_if.source                   result
);

  // input register
  logic              in_valid;
  cpls_pkg::item_t   in_word;

  // output register
  logic              out_valid;
  cpls_pkg::result_t out_word;

  cpls_pkg::result_t core_res;
  cpls_pkg::cfg_wr_t cfg;
  logic              advance;
  logic              out_free;

  // output register can take a new word when empty or being drained
  assign out_free = !out_valid || result.ready;
  // word in the input register goes through the core this cycle
  assign advance  = in_valid && out_free;
  // input register frees up whenever its word moves on
  assign item.ready = !in_valid || advance;

  assign cfg.en    = wr_en;
  assign cfg.index = wr_index;
  assign cfg.data  = wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (item.ready) in_valid <= item.valid;
      if (out_free)   out_valid <= in_valid;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      in_word.kind      <= item.kind;
      in_word.port      <= item.port;
      in_word.new_state <= item.new_state;
    end
    if (advance) out_word <= core_res;
  end

  cpls_core #(
    .PORTS(PORTS)
  ) u_core (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .step(advance),
    .item(in_word),
    .res (core_res)
  );

  // result channel
  assign result.valid        = out_valid;
  assign result.motor_enable = out_word.motor_enable;
  assign result.drive_lock   = out_word.drive_lock;
  assign result.drive_unlock = out_word.drive_unlock;
  assign result.allowed      = out_word.allowed;
  assign result.locked_mask  = out_word.locked_mask;
  assign result.phase_now    = out_word.phase_now;

endmodule

[src/cpls_core.sv]
// lock sequencer state, configuration registers and the single-pass update logic
// depends on cpls_pkg
module cpls_core #(
  parameter int PORTS = cpls_pkg::PORTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cpls_pkg::cfg_wr_t cfg,
  input  logic              step,
  input  cpls_pkg::item_t   item,
  output cpls_pkg::result_t res
);

  logic [cpls_pkg::TICK_W-1:0]  drive_ticks;
  logic [cpls_pkg::TICK_W-1:0]  settle_ticks;
  logic [PORTS-1:0]             confirmed, confirmed_next;
  logic [PORTS-1:0]             wanted, wanted_next;
  logic [cpls_pkg::PHASE_W-1:0] phase, phase_next;
  logic [cpls_pkg::PORT_W-1:0]  active_port, active_port_next;
  logic                         engaging, engaging_next;
  logic [cpls_pkg::TICK_W-1:0]  countdown, countdown_next;

  logic                           port_ok;
  logic [PORTS-1:0]               port_bit;
  logic [PORTS-1:0]               active_bit;
  logic [PORTS-1:0]               diff;
  logic [PORTS-1:0]               low_bit;
  logic [cpls_pkg::PORT_W-1:0]    first_port;
  logic [PORTS-1:0]               motor_bits;
  logic [cpls_pkg::MAX_PORTS-1:0] motor_wide;
  logic [cpls_pkg::MAX_PORTS-1:0] locked_wide;
  logic                           allowed;

  always_comb begin
    confirmed_next   = confirmed;
    wanted_next      = wanted;
    phase_next       = phase;
    active_port_next = active_port;
    engaging_next    = engaging;
    countdown_next   = countdown;
    allowed          = 1'b1;

    port_ok    = cpls_pkg::PORT_CMP_W'(item.port) < cpls_pkg::PORT_CMP_W'(PORTS);
    port_bit   = PORTS'(1) << item.port;
    active_bit = PORTS'(1) << active_port;

    // event of the word
    case (item.kind)
      cpls_pkg::KIND_TICK: begin
        if (phase != cpls_pkg::PH_IDLE) begin
          if (countdown > cpls_pkg::TICK_W'(1)) begin
            countdown_next = countdown - cpls_pkg::TICK_W'(1);
          end else if (phase == cpls_pkg::PH_DRIVE) begin
            confirmed_next = engaging ? (confirmed | active_bit) : (confirmed & ~active_bit);
            phase_next     = cpls_pkg::PH_SETTLE;
            countdown_next = settle_ticks;
          end else begin
            phase_next     = cpls_pkg::PH_IDLE;
            countdown_next = '0;
          end
        end
      end
      cpls_pkg::KIND_STATE: begin
        if (port_ok) begin
          if (item.new_state == cpls_pkg::ST_IDLE ||
              item.new_state == cpls_pkg::ST_DISCONNECTED) begin
            wanted_next = wanted & ~port_bit;
          end else if (item.new_state != cpls_pkg::ST_UNDEF) begin
            wanted_next = wanted | port_bit;
          end
        end
      end
      cpls_pkg::KIND_QUERY: begin
        if (item.new_state == cpls_pkg::ST_CHARGE || item.new_state == cpls_pkg::ST_FAN) begin
          allowed = port_ok && |(confirmed & port_bit);
        end
      end
      default: begin
      end
    endcase

    // start check: lowest port whose wanted and confirmed bits differ
    diff       = confirmed_next ^ wanted_next;
    low_bit    = diff & (~diff + PORTS'(1));
    first_port = '0;
    for (int i = 0; i < PORTS; i++) begin
      if (low_bit[i]) first_port = cpls_pkg::PORT_W'(i);
    end
    if (phase_next == cpls_pkg::PH_IDLE && |diff) begin
      active_port_next = first_port;
      engaging_next    = |(wanted_next & low_bit);
      phase_next       = cpls_pkg::PH_DRIVE;
      countdown_next   = drive_ticks;
    end

    motor_bits = (phase_next == cpls_pkg::PH_DRIVE) ? (PORTS'(1) << active_port_next) : '0;
    motor_wide = '0;
    motor_wide[PORTS-1:0] = motor_bits;
    locked_wide = '0;
    locked_wide[PORTS-1:0] = confirmed_next;

    res.motor_enable = motor_wide[cpls_pkg::MASK_W-1:0];
    res.drive_lock   = (phase_next == cpls_pkg::PH_DRIVE) && engaging_next;
    res.drive_unlock = (phase_next == cpls_pkg::PH_DRIVE) && !engaging_next;
    res.allowed      = allowed;
    res.locked_mask  = locked_wide[cpls_pkg::MASK_W-1:0];
    res.phase_now    = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_ticks  <= cpls_pkg::DRIVE_TICKS_RST;
      settle_ticks <= cpls_pkg::SETTLE_TICKS_RST;
      confirmed    <= '1;
      wanted       <= '0;
      phase        <= cpls_pkg::PH_IDLE;
      active_port  <= '0;
      engaging     <= 1'b0;
      countdown    <= '0;
    end else begin
      if (cfg.en) begin
        case (cfg.index)
          cpls_pkg::REG_DRIVE_TICKS:  drive_ticks  <= cfg.data;
          cpls_pkg::REG_SETTLE_TICKS: settle_ticks <= cfg.data;
          default: begin
          end
        endcase
      end
      if (step) begin
        confirmed   <= confirmed_next;
        wanted      <= wanted_next;
        phase       <= phase_next;
        active_port <= active_port_next;
        engaging    <= engaging_next;
        countdown   <= countdown_next;
      end
    end
  end

endmodule

[src/cpls_checker.sv]
// port-level checks of the charge port lock sequencer, bound to the top level
// depends on cpls_pkg and charge_port_lock_sequencer_top_macros.svh
`include "charge_port_lock_sequencer_top_macros.svh"

module cpls_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           res_valid,
  input logic                           res_ready,
  input logic [cpls_pkg::MASK_W-1:0]    motor_enable,
  input logic                           drive_lock,
  input logic                           drive_unlock,
  input logic [cpls_pkg::PHASE_W-1:0]   phase_now
);

  logic driving;
  assign driving = phase_now == cpls_pkg::PH_DRIVE;

  // a pending result is not withdrawn
  `CPLS_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid, "result valid dropped while stalled")

  // motor powered on exactly one port while driving, none otherwise
  `CPLS_ASSERT(a_motor_phase, clk, rst, !res_valid || (driving ? $onehot(motor_enable) : (motor_enable == '0)), "motor enable does not match phase")

  // exactly one direction while driving, none otherwise
  `CPLS_ASSERT(a_dir_phase, clk, rst, !res_valid || ((drive_lock ^ drive_unlock) == driving && !(drive_lock && drive_unlock)), "drive direction does not match phase")

  // only the three phases exist
  `CPLS_ASSERT(a_phase_code, clk, rst, !res_valid || phase_now == cpls_pkg::PH_IDLE || driving || phase_now == cpls_pkg::PH_SETTLE, "bad phase code")

endmodule

bind charge_port_lock_sequencer_top cpls_checker u_cpls_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .motor_enable(result.motor_enable),
  .drive_lock  (result.drive_lock),
  .drive_unlock(result.drive_unlock),
  .phase_now   (result.phase_now)
);

[tb/sv/tb_charge_port_lock_sequencer_top.sv]
// self-checking testbench for the charge port lock sequencer top level
// depends on cpls_pkg, the cpls_item_if/cpls_result_if interfaces and the rtl;
// a cycle-free predictor of the lock sequencing checks every result word in order
module tb_charge_port_lock_sequencer_top;
  import cpls_pkg::*;

  localparam int PORTS        = PORTS_DEF;
  localparam int CLK_PERIOD   = 8;
  localparam int LIMIT_CYCLES = 200_000;

  // codes the package does not name
  localparam logic [KIND_W-1:0]  KIND_NONE  = 2'd3;
  localparam logic [STATE_W-1:0] ST_CONNECT = 3'd3;
  localparam logic [STATE_W-1:0] ST_WAIT    = 3'd4;
  localparam logic [STATE_W-1:0] ST_PAUSED  = 3'd7;

  logic                  clk;
  logic                  rst;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  wr_index;
  logic [CFG_DATA_W-1:0] wr_data;

  cpls_item_if   word_in ();
  cpls_result_if word_out ();

  charge_port_lock_sequencer_top #(.PORTS(PORTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .item     (word_in),
    .result   (word_out)
  );

  // predicted sequencer state, mirrors what the block should hold
  logic [MASK_W-1:0]  m_locked;
  logic [MASK_W-1:0]  m_wanted;
  logic [PHASE_W-1:0] m_phase;
  logic [PORT_W-1:0]  m_port;
  logic               m_engage;
  logic [TICK_W-1:0]  m_count;
  logic [TICK_W-1:0]  m_drive_len;
  logic [TICK_W-1:0]  m_settle_len;

  // result words still owed by the block, oldest first
  result_t status_due[$];

  int error_count = 0;
  bit tx_jitter   = 1'b1;   // sender inserts random gaps
  bit rx_jitter   = 1'b1;   // receiver drops ready at random
  bit sink_hold_req = 1'b0; // asks the receiver for one long stall
  int sink_hold_len = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // hard limit on the run
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("[charge_port_lock_sequencer_top] ERROR");
    $finish;
  end

  // apply one accepted word to the predicted state and queue its result word
  function automatic void advance_lock_model(input item_t w);
    result_t           r;
    logic [MASK_W-1:0] sel;
    logic [MASK_W-1:0] diff;
    int                p;
    int                first;
    r = '0;
    r.allowed = 1'b1;
    // the word's own event comes first
    case (w.kind)
      KIND_TICK: begin
        if (m_phase != PH_IDLE) begin
          if (m_count > 1) begin
            m_count = m_count - 1'b1;
          end else if (m_phase == PH_DRIVE) begin
            // move done: confirmed bit follows the direction we drove
            sel = MASK_W'(1) << m_port;
            if (m_engage) m_locked = m_locked | sel;
            else m_locked = m_locked & ~sel;
            m_phase = PH_SETTLE;
            m_count = m_settle_len;
          end else begin
            m_phase = PH_IDLE;
            m_count = '0;
          end
        end
      end
      KIND_STATE: begin
        // out-of-range ports are ignored
        if (w.port < PORTS) begin
          sel = MASK_W'(1) << w.port;
          if (w.new_state == ST_IDLE || w.new_state == ST_DISCONNECTED)
            m_wanted = m_wanted & ~sel;
          else if (w.new_state != ST_UNDEF)
            m_wanted = m_wanted | sel;
        end
      end
      KIND_QUERY: begin
        // only charge and fan need a confirmed lock
        if (w.new_state == ST_CHARGE || w.new_state == ST_FAN)
          r.allowed = (w.port < PORTS) ? m_locked[w.port] : 1'b0;
      end
      default: ;
    endcase
    // then, when idle, start a move on the lowest port that disagrees
    if (m_phase == PH_IDLE) begin
      diff = m_locked ^ m_wanted;
      if (diff != '0) begin
        first = 0;
        for (p = PORTS - 1; p >= 0; p--)
          if (diff[p]) first = p;
        m_port   = PORT_W'(first);
        m_engage = m_wanted[first];
        m_phase  = PH_DRIVE;
        m_count  = m_drive_len;
      end
    end
    if (m_phase == PH_DRIVE) begin
      r.motor_enable = MASK_W'(1) << m_port;
      r.drive_lock   = m_engage;
      r.drive_unlock = !m_engage;
    end
    r.locked_mask = m_locked;
    r.phase_now   = m_phase;
    status_due.push_back(r);
  endfunction

  function automatic item_t make_word(input logic [KIND_W-1:0] kind,
                                      input int port, input logic [STATE_W-1:0] st);
    item_t w;
    w.kind      = kind;
    w.port      = PORT_W'(port);
    w.new_state = st;
    return w;
  endfunction

  // random word; tick_pct sets how much of the mix is timer ticks
  function automatic item_t rand_word(input int tick_pct);
    item_t w;
    int    roll;
    int    rest;
    roll = $urandom_range(99);
    rest = 100 - tick_pct;
    // mostly valid ports, sometimes the two past the end
    w.port      = ($urandom_range(9) == 0) ? PORT_W'($urandom_range(7))
                                           : PORT_W'($urandom_range(PORTS - 1));
    w.new_state = STATE_W'($urandom_range(7));
    if (roll < tick_pct) begin
      w.kind = KIND_TICK;
    end else if (roll < tick_pct + rest / 2) begin
      w.kind = KIND_STATE;
      // bias toward clears so the wanted mask keeps moving both ways
      if ($urandom_range(1))
        w.new_state = $urandom_range(1) ? ST_IDLE : ST_DISCONNECTED;
    end else if (roll < 98) begin
      w.kind = KIND_QUERY;
      if ($urandom_range(1))
        w.new_state = $urandom_range(1) ? ST_CHARGE : ST_FAN;
    end else begin
      w.kind = KIND_NONE;
    end
    return w;
  endfunction

  // offer one word and wait for the handshake; called at a rising edge
  task automatic send_word(input item_t w);
    if (tx_jitter && $urandom_range(99) < 6) begin
      word_in.valid <= 1'b0;
      @(posedge clk);
    end
    word_in.valid     <= 1'b1;
    word_in.kind      <= w.kind;
    word_in.port      <= w.port;
    word_in.new_state <= w.new_state;
    @(posedge clk);
    while (!word_in.ready) @(posedge clk);
    advance_lock_model(w);
  endtask

  // sender goes quiet until every owed result word is back
  task automatic wait_for_results();
    word_in.valid <= 1'b0;
    @(posedge clk);
    while (status_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // register write; only called with nothing in flight
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    if (idx == REG_DRIVE_TICKS) m_drive_len = val;
    else m_settle_len = val;
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_ticks(input logic [TICK_W-1:0] drive, input logic [TICK_W-1:0] settle);
    wait_for_results();
    write_reg(REG_DRIVE_TICKS, drive);
    write_reg(REG_SETTLE_TICKS, settle);
  endtask

  task automatic run_random(input int count, input int tick_pct);
    repeat (count) send_word(rand_word(tick_pct));
  endtask

  // reset values: all ports confirmed locked, none wanted, so port 0 starts unlocking
  task automatic test_after_reset();
    send_word(make_word(KIND_NONE, 7, ST_PAUSED));
    send_word(make_word(KIND_QUERY, 0, ST_CHARGE));
    send_word(make_word(KIND_QUERY, 5, ST_FAN));
    send_word(make_word(KIND_TICK, 0, ST_UNDEF));
  endtask

  // every state code, the tick, state and query kinds, out-of-range ports, queries before and after moves
  task automatic test_port_events();
    set_ticks(8'd1, 8'd1);
    send_word(make_word(KIND_QUERY, 6, ST_CHARGE));
    send_word(make_word(KIND_QUERY, 7, ST_FAN));
    send_word(make_word(KIND_QUERY, 7, ST_WAIT));
    send_word(make_word(KIND_STATE, 7, ST_CONNECT));
    send_word(make_word(KIND_STATE, 6, ST_CHARGE));
    send_word(make_word(KIND_STATE, 0, ST_UNDEF));
    send_word(make_word(KIND_STATE, 1, ST_IDLE));
    send_word(make_word(KIND_STATE, 2, ST_DISCONNECTED));
    send_word(make_word(KIND_STATE, 3, ST_CONNECT));
    send_word(make_word(KIND_STATE, 4, ST_WAIT));
    send_word(make_word(KIND_STATE, 5, ST_CHARGE));
    send_word(make_word(KIND_STATE, 0, ST_FAN));
    send_word(make_word(KIND_STATE, 1, ST_PAUSED));
    repeat (4) send_word(make_word(KIND_TICK, 5, ST_PAUSED));
    send_word(make_word(KIND_QUERY, 3, ST_CHARGE));
    send_word(make_word(KIND_QUERY, 0, ST_FAN));
    send_word(make_word(KIND_QUERY, 2, ST_CHARGE));
  endtask

  // a tick count of zero behaves like one
  task automatic test_zero_ticks();
    set_ticks(8'd0, 8'd0);
    run_random(150, 50);
  endtask

  // receiver stalls long enough for the block to fill and push back on the sender
  task automatic test_receiver_hold();
    set_ticks(8'd3, 8'd2);
    sink_hold_len = 200;
    sink_hold_req = 1'b1;
    run_random(40, 50);
  endtask

  // sender pauses mid-stream until everything has drained, then resumes
  task automatic test_sender_pause();
    set_ticks(8'd4, 8'd1);
    run_random(60, 55);
    wait_for_results();
    run_random(60, 55);
  endtask

  // walk through several tick settings, the extremes among them
  task automatic test_tick_settings();
    set_ticks(8'd1, 8'd1);
    run_random(150, 45);
    // longest moves: almost all ticks so at least one full drive finishes
    set_ticks(8'd255, 8'd255);
    run_random(300, 97);
    set_ticks(8'd1, 8'd255);
    run_random(120, 70);
    set_ticks(TICK_W'($urandom_range(2, 20)), TICK_W'($urandom_range(1, 20)));
    run_random(130, 65);
    // a stretch with no idling on either side
    tx_jitter = 1'b0;
    rx_jitter = 1'b0;
    set_ticks(TICK_W'($urandom_range(2, 12)), TICK_W'($urandom_range(1, 12)));
    run_random(130, 60);
    tx_jitter = 1'b1;
    rx_jitter = 1'b1;
    set_ticks(TICK_W'($urandom_range(1, 30)), TICK_W'($urandom_range(1, 30)));
    run_random(130, 70);
    set_ticks(DRIVE_TICKS_RST, SETTLE_TICKS_RST);
    run_random(150, 90);
  endtask

  // receiver: random ready drops, plus one long hold counted here
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    word_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        stall_left = sink_hold_len;
      end
      if (stall_left > 0) begin
        stall_left--;
        word_out.ready <= 1'b0;
      end else begin
        word_out.ready <= !(rx_jitter && $urandom_range(99) < 6);
      end
    end
  end

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  // checker: every accepted result word against the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && word_out.valid && word_out.ready) begin
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual motor %0h mask %0h phase %0h",
                 $time, word_out.motor_enable, word_out.locked_mask, word_out.phase_now);
        error_count++;
      end else begin
        want = status_due.pop_front();
        check_field("motor_enable", 8'(want.motor_enable), 8'(word_out.motor_enable));
        check_field("drive_lock", 8'(want.drive_lock), 8'(word_out.drive_lock));
        check_field("drive_unlock", 8'(want.drive_unlock), 8'(word_out.drive_unlock));
        check_field("allowed", 8'(want.allowed), 8'(word_out.allowed));
        check_field("locked_mask", 8'(want.locked_mask), 8'(word_out.locked_mask));
        check_field("phase_now", 8'(want.phase_now), 8'(word_out.phase_now));
      end
    end
  end

  // main sequence
  initial begin
    rst               = 1'b1;
    wr_en             = 1'b0;
    wr_index          = REG_DRIVE_TICKS;
    wr_data           = '0;
    word_in.valid     = 1'b0;
    word_in.kind      = KIND_TICK;
    word_in.port      = '0;
    word_in.new_state = ST_UNDEF;
    // predicted state after reset
    m_locked     = '1;
    m_wanted     = '0;
    m_phase      = PH_IDLE;
    m_port       = '0;
    m_engage     = 1'b0;
    m_count      = '0;
    m_drive_len  = DRIVE_TICKS_RST;
    m_settle_len = SETTLE_TICKS_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_port_events();
    test_zero_ticks();
    test_receiver_hold();
    test_sender_pause();
    test_tick_settings();

    // let the last words drain and the pipeline settle
    wait_for_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("[charge_port_lock_sequencer_top] OK");
    end else begin
      $display("[charge_port_lock_sequencer_top] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+src
src/cpls_pkg.sv
src/cpls_if.sv
src/cpls_core.sv
src/charge_port_lock_sequencer_top.sv
src/cpls_checker.sv
tb/sv/tb_charge_port_lock_sequencer_top.sv
